// File: rtl/clc_pkg.sv
// package: shared types, constants and helpers of the card number luhn classifier
`timescale 1ns / 1ps
`default_nettype none
package clc_pkg;

   localparam int NUM_W     = 63;
   localparam int SRC_W     = 64;
   localparam int DIGITS    = 20;
   localparam int BCD_W     = DIGITS * 4;
   localparam int STEP_BITS = 4;
   localparam int CNT_W     = 5;
   localparam int SUM_W     = 4;
   localparam int STEP_W    = 4;

   localparam logic [STEP_W-1:0] CONV_LAST = STEP_W'(SRC_W / STEP_BITS - 1);
   localparam logic [STEP_W-1:0] PAIR_LAST = STEP_W'(DIGITS / 2 - 1);

   localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(13);
   localparam logic [CNT_W-1:0] LEN_AMEX  = CNT_W'(15);
   localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SUM,
      ST_CLASS
   } state_type;

   typedef enum logic [1:0] {
      CLASS_INVALID = 2'd0,
      CLASS_AMEX    = 2'd1,
      CLASS_MASTER  = 2'd2,
      CLASS_VISA    = 2'd3
   } card_class_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } luhn_acc_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic sum;
      logic finish;
   } ctrl_type;

   // doubled digit with its two decimal digits added
   function automatic logic [3:0] double_digit(input logic [3:0] d);
      logic [4:0] p;
      p = {d, 1'b0};
      if (p >= 5'd10) begin
         return 4'(p - 5'd9);
      end
      return 4'(p);
   endfunction

endpackage
`default_nettype wire

// File: rtl/card_number_luhn_classifier.sv
// top level: sequencer, working registers, classing and result register
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  request | req_valid req_ready req_card_number     | in
//  result  | rsp_valid rsp_ready rsp_card_class      | out
//          | rsp_luhn_ok rsp_digit_count             |
//
// one beat runs from accept to result through the binary to bcd unit (4 bits per
// cycle over 64 bits), the luhn unit (one digit pair per cycle) and the classing
// step; the next beat is accepted only once the sequencer is back in idle.
// synchronous reset clears the sequencer and the result valid.
// req_ready is high only while idle; a held result stalls the classing step.
`timescale 1ns / 1ps
`default_nettype none
module card_number_luhn_classifier (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [clc_pkg::NUM_W-1:0] req_card_number,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [1:0]                rsp_card_class,
   output logic                           rsp_luhn_ok,
   output logic      [clc_pkg::CNT_W-1:0] rsp_digit_count
);
   import clc_pkg::*;

   state_type       state_ff, state_in;
   ctrl_type        ctrl;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SRC_W-1:0]  src_ff, src_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   luhn_acc_type      acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   card_class_type    rsp_class_ff, rsp_class_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [BCD_W-1:0]  dabble_out;
   luhn_acc_type      luhn_out;
   logic [3:0]        lead_digit;
   logic [3:0]        next_digit;
   card_class_type    card_class;

   clc_dabble_unit u_dabble (
      .bcd_in  (bcd_ff),
      .bits_in (src_ff[SRC_W-1 -: STEP_BITS]),
      .bcd_out (dabble_out)
   );

   clc_luhn_unit u_luhn (
      .pair_in (bcd_ff[{step_ff, 3'b000} +: 8]),
      .pos_in  (step_ff),
      .acc_in  (acc_ff),
      .acc_out (luhn_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (step_ff == CONV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (step_ff == PAIR_LAST) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_CONV: begin
            ctrl.conv = 1'b1;
         end
         ST_SUM: begin
            ctrl.sum = 1'b1;
         end
         ST_CLASS: begin
            ctrl.finish = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // leading digits for the lengths that carry a class
   always_comb begin
      lead_digit = 4'd0;
      next_digit = 4'd0;
      unique case (acc_ff.count)
         LEN_SHORT: begin
            lead_digit = bcd_ff[(int'(LEN_SHORT) - 1) * 4 +: 4];
            next_digit = bcd_ff[(int'(LEN_SHORT) - 2) * 4 +: 4];
         end
         LEN_AMEX: begin
            lead_digit = bcd_ff[(int'(LEN_AMEX) - 1) * 4 +: 4];
            next_digit = bcd_ff[(int'(LEN_AMEX) - 2) * 4 +: 4];
         end
         LEN_LONG: begin
            lead_digit = bcd_ff[(int'(LEN_LONG) - 1) * 4 +: 4];
            next_digit = bcd_ff[(int'(LEN_LONG) - 2) * 4 +: 4];
         end
         default: begin
            lead_digit = 4'd0;
            next_digit = 4'd0;
         end
      endcase
   end

   always_comb begin
      card_class = CLASS_INVALID;
      if (acc_ff.sum == SUM_W'(0)) begin
         unique case (acc_ff.count)
            LEN_SHORT: begin
               if (lead_digit == 4'd4) begin
                  card_class = CLASS_VISA;
               end
            end
            LEN_AMEX: begin
               if (lead_digit == 4'd3 && (next_digit == 4'd4 || next_digit == 4'd7)) begin
                  card_class = CLASS_AMEX;
               end
            end
            LEN_LONG: begin
               priority if (lead_digit == 4'd5 && next_digit >= 4'd1 &&
                            next_digit <= 4'd5) begin
                  card_class = CLASS_MASTER;
               end else if (lead_digit == 4'd4) begin
                  card_class = CLASS_VISA;
               end else begin
                  card_class = CLASS_INVALID;
               end
            end
            default: begin
               card_class = CLASS_INVALID;
            end
         endcase
      end
   end

   // datapath next values
   always_comb begin
      step_in      = step_ff;
      src_in       = src_ff;
      bcd_in       = bcd_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;

      if (ctrl.load) begin
         step_in = '0;
         src_in  = {1'b0, req_card_number};
         bcd_in  = '0;
         acc_in  = '0;
      end
      if (ctrl.conv) begin
         src_in  = {src_ff[SRC_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
         bcd_in  = dabble_out;
         step_in = (step_ff == CONV_LAST) ? '0 : STEP_W'(step_ff + 1'b1);
      end
      if (ctrl.sum) begin
         acc_in  = luhn_out;
         step_in = STEP_W'(step_ff + 1'b1);
      end

      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = card_class;
         rsp_ok_in    = (acc_ff.sum == SUM_W'(0));
         rsp_count_in = acc_ff.count;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      src_ff       <= src_in;
      bcd_ff       <= bcd_in;
      acc_ff       <= acc_in;
      rsp_class_ff <= rsp_class_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_class  = rsp_class_ff;
   assign rsp_luhn_ok     = rsp_ok_ff;
   assign rsp_digit_count = rsp_count_ff;

endmodule
`default_nettype wire

// File: rtl/clc_dabble_unit.sv
// binary to bcd shift unit, one shift-and-correct step for each of the STEP_BITS input bits
`timescale 1ns / 1ps
`default_nettype none
module clc_dabble_unit (
   input  wire logic [clc_pkg::BCD_W-1:0]     bcd_in,
   input  wire logic [clc_pkg::STEP_BITS-1:0] bits_in,
   output logic      [clc_pkg::BCD_W-1:0]     bcd_out
);
   import clc_pkg::*;

   logic [BCD_W-1:0] work;

   always_comb begin
      work = bcd_in;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (work[d*4 +: 4] >= 4'd5) begin
               work[d*4 +: 4] = work[d*4 +: 4] + 4'd3;
            end
         end
         work = {work[BCD_W-2:0], bits_in[STEP_BITS-1-s]};
      end
      bcd_out = work;
   end

endmodule
`default_nettype wire

// File: rtl/clc_luhn_unit.sv
// luhn accumulator step over one pair of decimal digits
`timescale 1ns / 1ps
`default_nettype none
module clc_luhn_unit (
   input  wire logic [7:0]                 pair_in,
   input  wire logic [clc_pkg::STEP_W-1:0] pos_in,
   input  wire clc_pkg::luhn_acc_type      acc_in,
   output clc_pkg::luhn_acc_type           acc_out
);
   import clc_pkg::*;

   logic [3:0] d_lo;
   logic [3:0] d_hi;
   logic [3:0] d_dbl;
   logic [4:0] raw;

   always_comb begin
      d_lo  = pair_in[3:0];
      d_hi  = pair_in[7:4];
      d_dbl = double_digit(d_hi);
      raw   = 5'(acc_in.sum) + 5'(d_lo) + 5'(d_dbl);

      // running sum kept modulo ten
      priority if (raw >= 5'd20) begin
         acc_out.sum = SUM_W'(raw - 5'd20);
      end else if (raw >= 5'd10) begin
         acc_out.sum = SUM_W'(raw - 5'd10);
      end else begin
         acc_out.sum = SUM_W'(raw);
      end

      // digit count follows the highest nonzero digit seen
      priority if (d_hi != 4'd0) begin
         acc_out.count = {pos_in, 1'b0} + CNT_W'(2);
      end else if (d_lo != 4'd0) begin
         acc_out.count = {pos_in, 1'b0} + CNT_W'(1);
      end else begin
         acc_out.count = acc_in.count;
      end
   end

endmodule
`default_nettype wire
